// File: design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the paged frame allocator
// Field widths, opcodes, register selects, beat structs and the sequencer
// state type used by all allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  // Field widths
  localparam int MEM_W      = 25;  // memory_size register and divider dividend
  localparam int FSZ_W      = 17;  // frame_size register and divider divisor
  localparam int BYTES_W    = 24;
  localparam int PID_IN_W   = 16;
  localparam int ADDR_W     = 24;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int DIV_STEP_W = $clog2(MEM_W);

  // Register reset values
  localparam logic [MEM_W-1:0] MEM_SIZE_RESET   = MEM_W'(16384);
  localparam logic [FSZ_W-1:0] FRAME_SIZE_RESET = FSZ_W'(64);

  // Register select (byte address bit 2)
  localparam logic REG_MEM_SIZE   = 1'b0;
  localparam logic REG_FRAME_SIZE = 1'b1;

  // Opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [PID_IN_W-1:0] process_id;
    logic [BYTES_W-1:0]  bytes_required;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] base_address;
    logic              memory_full;
  } rsp_t;

  typedef struct packed {
    logic             reload;
    logic [MEM_W-1:0] memory_size;
    logic [FSZ_W-1:0] frame_size;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [MEM_W-1:0] dividend;
    logic [FSZ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MEM_W-1:0] quotient;
    logic [FSZ_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_CNT_DIV,
    S_CNT_WAIT,
    S_CLEAR,
    S_IDLE,
    S_NEED_DIV,
    S_NEED_WAIT,
    S_HEAD_RD,
    S_BASE,
    S_POP,
    S_FREE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: design/pfa_div.sv
// ----------------------------------------------------------------------------
// pfa_div: iterative restoring divider
// One quotient bit per cycle; shared between the frame count and the
// frames-needed computation.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pfa_pkg::div_req_t req,
  output pfa_pkg::div_rsp_t      rsp
);

  logic                              busy;
  logic                              done;
  logic [pfa_pkg::DIV_STEP_W-1:0]    cnt;
  logic [pfa_pkg::MEM_W-1:0]         quot;
  logic [pfa_pkg::FSZ_W-1:0]         rem;
  logic [pfa_pkg::FSZ_W-1:0]         dvsr;
  logic [pfa_pkg::FSZ_W:0]           rem_shift;
  logic [pfa_pkg::FSZ_W:0]           diff;
  logic                              take;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_shift = {rem, quot[pfa_pkg::MEM_W-1]};
    diff      = rem_shift - {1'b0, dvsr};
    take      = (rem_shift >= {1'b0, dvsr});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == pfa_pkg::DIV_STEP_W'(pfa_pkg::MEM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (busy) begin
      quot <= {quot[pfa_pkg::MEM_W-2:0], take};
      rem  <= take ? diff[pfa_pkg::FSZ_W-1:0] : rem_shift[pfa_pkg::FSZ_W-1:0];
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// File: design/pfa_apb.sv
// ----------------------------------------------------------------------------
// pfa_apb: configuration register port
// Holds memory_size and frame_size; flags every completed write so the
// allocator reloads its free queue and owner table.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_apb (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pfa_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [pfa_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [pfa_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  output pfa_pkg::cfg_t                       cfg
);

  logic                      wr;
  logic [pfa_pkg::MEM_W-1:0] memory_size;
  logic [pfa_pkg::FSZ_W-1:0] frame_size;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_size <= pfa_pkg::MEM_SIZE_RESET;
      frame_size  <= pfa_pkg::FRAME_SIZE_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        pfa_pkg::REG_MEM_SIZE:   memory_size <= pwdata[pfa_pkg::MEM_W-1:0];
        pfa_pkg::REG_FRAME_SIZE: frame_size  <= pwdata[pfa_pkg::FSZ_W-1:0];
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (paddr[2])
      pfa_pkg::REG_MEM_SIZE:   prdata = pfa_pkg::APB_DATA_W'(memory_size);
      pfa_pkg::REG_FRAME_SIZE: prdata = pfa_pkg::APB_DATA_W'(frame_size);
    endcase
  end

  assign cfg.reload      = wr;
  assign cfg.memory_size = memory_size;
  assign cfg.frame_size  = frame_size;

endmodule

`default_nettype wire

// File: design/paged_frame_allocator.sv
// ----------------------------------------------------------------------------
// paged_frame_allocator: free-frame queue and owner table allocator
// Hands out fixed-size frames to processes and releases them per process.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (req_valid / req_stall); each gives exactly one
//   result beat on rsp (rsp_valid / rsp_stall), unless a register write
//   restarts the reload sequence first. One request is worked at a time;
//   req_stall stays high until the sequencer is back in idle.
//   Allocate: the frames-needed figure comes from the shared divider,
//   then one frame is popped from the queue memory per cycle; a failing
//   allocate goes to its result once the division is done.
//   Free: one owner-table entry read per cycle.
//   After reset and after every register write the frame count is divided
//   out and a clearing pass reloads the queue and clears the owner table;
//   no request is taken meanwhile, register writes are taken at any time.
//   The result sits in an output register: a stalled receiver holds it and
//   the block may take and work the next request, finishing only once the
//   output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_frame_allocator #(
  parameter int NUM_FRAMES = 256,
  parameter int PID_BITS   = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire pfa_pkg::req_t                  req,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output pfa_pkg::rsp_t                       rsp,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pfa_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [pfa_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [pfa_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  localparam int FB     = $clog2(NUM_FRAMES);
  localparam int CW     = $clog2(NUM_FRAMES + 1);
  localparam int PROD_W = FB + pfa_pkg::FSZ_W;

  pfa_pkg::state_t   state;
  pfa_pkg::state_t   state_next;
  pfa_pkg::cfg_t     cfg;
  pfa_pkg::div_req_t div_req;
  pfa_pkg::div_rsp_t div_rsp;

  logic [pfa_pkg::FSZ_W-1:0]   fsz_eff;
  logic                        req_acc;
  logic                        out_load;

  // Latched request
  logic                        op_q;
  logic [PID_BITS-1:0]         pid_q;
  logic [pfa_pkg::BYTES_W-1:0] bytes_q;
  logic [PID_BITS+pfa_pkg::PID_IN_W-1:0] pid_ext;

  // Queue and bookkeeping
  logic [FB-1:0]               head;
  logic [FB-1:0]               tail;
  logic [CW-1:0]               free_cnt;
  logic [CW-1:0]               pop_left;
  logic                        pend;
  logic [CW-1:0]               sidx;
  logic                        chk;
  logic [FB-1:0]               chk_idx;
  logic                        status_q;
  logic [pfa_pkg::ADDR_W-1:0]  base_q;

  // Divider derived values
  logic [CW-1:0]               cnt_calc;
  logic [pfa_pkg::MEM_W-1:0]   need_calc;
  logic                        need_fail;

  // Base address product
  logic [PROD_W-1:0]                   prod;
  logic [PROD_W+pfa_pkg::ADDR_W-1:0]   prod_ext;

  // Free queue memory
  logic [FB-1:0]               queue [NUM_FRAMES];
  logic                        q_we;
  logic [FB-1:0]               q_waddr;
  logic [FB-1:0]               q_wdata;
  logic [FB-1:0]               q_rdata;

  // Owner table memory: {valid, pid}
  logic [PID_BITS:0]           owner [NUM_FRAMES];
  logic                        o_we;
  logic [FB-1:0]               o_waddr;
  logic [PID_BITS:0]           o_wdata;
  logic                        o_re;
  logic [FB-1:0]               o_raddr;
  logic [PID_BITS:0]           o_rdata;
  logic                        hit;

  pfa_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pfa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Treat a zero frame size as one byte
  assign fsz_eff = (cfg.frame_size == '0) ? pfa_pkg::FSZ_W'(1) : cfg.frame_size;

  assign req_stall = (state != pfa_pkg::S_IDLE) || cfg.reload;
  assign req_acc   = req_valid && !req_stall;

  // Keep the low PID_BITS bits of the process id
  assign pid_ext = {{PID_BITS{1'b0}}, req.process_id};

  // Saturate the frame count, round the frames needed up
  always_comb begin
    cnt_calc  = (div_rsp.quotient >= pfa_pkg::MEM_W'(NUM_FRAMES)) ?
                CW'(NUM_FRAMES) : div_rsp.quotient[CW-1:0];
    need_calc = div_rsp.quotient + pfa_pkg::MEM_W'(div_rsp.remainder != '0);
    need_fail = (free_cnt == '0) || (need_calc > pfa_pkg::MEM_W'(free_cnt));
  end

  assign prod     = q_rdata * fsz_eff;
  assign prod_ext = {{pfa_pkg::ADDR_W{1'b0}}, prod};

  assign hit = chk && o_rdata[PID_BITS] && (o_rdata[PID_BITS-1:0] == pid_q);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfa_pkg::S_CNT_DIV:  state_next = pfa_pkg::S_CNT_WAIT;
      pfa_pkg::S_CNT_WAIT: begin
        if (div_rsp.done) state_next = pfa_pkg::S_CLEAR;
      end
      pfa_pkg::S_CLEAR: begin
        if (sidx == CW'(NUM_FRAMES - 1)) state_next = pfa_pkg::S_IDLE;
      end
      pfa_pkg::S_IDLE: begin
        if (req_acc) begin
          state_next = (req.opcode == pfa_pkg::OP_FREE) ?
                       pfa_pkg::S_FREE : pfa_pkg::S_NEED_DIV;
        end
      end
      pfa_pkg::S_NEED_DIV:  state_next = pfa_pkg::S_NEED_WAIT;
      pfa_pkg::S_NEED_WAIT: begin
        if (div_rsp.done) begin
          state_next = need_fail ? pfa_pkg::S_DONE : pfa_pkg::S_HEAD_RD;
        end
      end
      pfa_pkg::S_HEAD_RD: state_next = pfa_pkg::S_BASE;
      pfa_pkg::S_BASE:    state_next = pfa_pkg::S_POP;
      pfa_pkg::S_POP: begin
        if (pop_left == '0 && !pend) state_next = pfa_pkg::S_DONE;
      end
      pfa_pkg::S_FREE: begin
        if (sidx == CW'(NUM_FRAMES) && !chk) state_next = pfa_pkg::S_DONE;
      end
      pfa_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) state_next = pfa_pkg::S_IDLE;
      end
      default: state_next = pfa_pkg::S_CNT_DIV;
    endcase
    // A register write restarts the reload sequence
    if (cfg.reload) state_next = pfa_pkg::S_CNT_DIV;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pfa_pkg::S_CNT_DIV;
    else     state <= state_next;
  end

  // Sequencer outputs: divider start and memory ports
  always_comb begin
    div_req.start    = (state == pfa_pkg::S_CNT_DIV) || (state == pfa_pkg::S_NEED_DIV);
    div_req.dividend = (state == pfa_pkg::S_CNT_DIV) ?
                       cfg.memory_size : pfa_pkg::MEM_W'(bytes_q);
    div_req.divisor  = fsz_eff;

    q_we    = 1'b0;
    q_waddr = tail;
    q_wdata = chk_idx;
    o_we    = 1'b0;
    o_waddr = chk_idx;
    o_wdata = '0;
    o_re    = 1'b0;
    o_raddr = sidx[FB-1:0];
    out_load = 1'b0;

    unique case (state)
      pfa_pkg::S_CLEAR: begin
        q_we    = 1'b1;
        q_waddr = sidx[FB-1:0];
        q_wdata = sidx[FB-1:0];
        o_we    = 1'b1;
        o_waddr = sidx[FB-1:0];
      end
      pfa_pkg::S_POP: begin
        o_we    = pend;
        o_waddr = q_rdata;
        o_wdata = {1'b1, pid_q};
      end
      pfa_pkg::S_FREE: begin
        o_re  = (sidx != CW'(NUM_FRAMES));
        o_we  = hit;
        q_we  = hit && (free_cnt < CW'(NUM_FRAMES));
      end
      pfa_pkg::S_DONE: begin
        out_load = !rsp_valid || !rsp_stall;
      end
      default: begin
        q_we = 1'b0;
      end
    endcase
  end

  // Free queue: write one entry, read the head every cycle
  always_ff @(posedge clk) begin
    if (q_we) queue[q_waddr] <= q_wdata;
    q_rdata <= queue[head];
  end

  // Owner table
  always_ff @(posedge clk) begin
    if (o_we) owner[o_waddr] <= o_wdata;
    if (o_re) o_rdata <= owner[o_raddr];
  end

  // Bookkeeping control
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      free_cnt <= '0;
      pop_left <= '0;
      pend     <= 1'b0;
      sidx     <= '0;
      chk      <= 1'b0;
    end else begin
      unique case (state)
        pfa_pkg::S_CNT_WAIT: begin
          if (div_rsp.done) begin
            head     <= '0;
            tail     <= (cnt_calc == CW'(NUM_FRAMES)) ? '0 : cnt_calc[FB-1:0];
            free_cnt <= cnt_calc;
            sidx     <= '0;
          end
        end
        pfa_pkg::S_CLEAR: sidx <= sidx + 1'b1;
        pfa_pkg::S_IDLE: begin
          sidx <= '0;
          chk  <= 1'b0;
        end
        pfa_pkg::S_NEED_WAIT: begin
          if (div_rsp.done) pop_left <= need_calc[CW-1:0];
        end
        pfa_pkg::S_BASE: pend <= 1'b0;
        pfa_pkg::S_POP: begin
          if (pop_left != '0) begin
            head     <= (head == FB'(NUM_FRAMES - 1)) ? '0 : head + 1'b1;
            free_cnt <= free_cnt - 1'b1;
            pop_left <= pop_left - 1'b1;
            pend     <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        pfa_pkg::S_FREE: begin
          // Issue the next read while checking the previous entry
          if (sidx != CW'(NUM_FRAMES)) begin
            chk  <= 1'b1;
            sidx <= sidx + 1'b1;
          end else begin
            chk <= 1'b0;
          end
          if (hit && (free_cnt < CW'(NUM_FRAMES))) begin
            tail     <= (tail == FB'(NUM_FRAMES - 1)) ? '0 : tail + 1'b1;
            free_cnt <= free_cnt + 1'b1;
          end
        end
        default: begin
          pend <= pend;
        end
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      pfa_pkg::S_IDLE: begin
        if (req_acc) begin
          op_q     <= req.opcode;
          pid_q    <= pid_ext[PID_BITS-1:0];
          bytes_q  <= req.bytes_required;
          status_q <= pfa_pkg::ST_OK;
          base_q   <= '0;
        end
      end
      pfa_pkg::S_NEED_WAIT: begin
        if (div_rsp.done && need_fail && (op_q == pfa_pkg::OP_ALLOC)) begin
          status_q <= pfa_pkg::ST_FAIL;
        end
      end
      pfa_pkg::S_BASE: base_q <= prod_ext[pfa_pkg::ADDR_W-1:0];
      pfa_pkg::S_FREE: begin
        if (sidx != CW'(NUM_FRAMES)) chk_idx <= sidx[FB-1:0];
      end
      default: begin
        base_q <= base_q;
      end
    endcase
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status       <= status_q;
      rsp.base_address <= base_q;
      rsp.memory_full  <= (free_cnt == '0);
    end
  end

endmodule

`default_nettype wire
